### design/elv_pkg.sv
// ----------------------------------------------------------------------------
// Elevator scheduler package
// Shared constants, codes and the request slot layout of the LOOK scheduler.
// ----------------------------------------------------------------------------
package elv_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TAG_WIDTH   = 8;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int FLOOR_W = 6;
   localparam int FCNT_W  = 7;
   localparam int LOAD_W  = 5;

   typedef enum logic [2:0] {
      EV_ACCEPTED = 3'd0,
      EV_REJECTED = 3'd1,
      EV_DROP_OFF = 3'd2,
      EV_PICK_UP  = 3'd3,
      EV_STEP_END = 3'd4
   } event_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DN   = 2'd2
   } dir_type;

   typedef enum logic [1:0] {
      SLOT_WAIT = 2'd0,
      SLOT_DONE = 2'd1,
      SLOT_RIDE = 2'd2
   } slot_status_type;

   typedef enum logic {
      REQ_ENQUEUE = 1'b0,
      REQ_TICK    = 1'b1
   } req_kind_type;

   typedef enum logic {
      CSR_FLOOR_COUNT  = 1'b0,
      CSR_CAR_CAPACITY = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [FLOOR_W-1:0]   src_floor;
      logic [FLOOR_W-1:0]   dst_floor;
      logic [TAG_WIDTH-1:0] tag;
      slot_status_type      status;
   } slot_type;

endpackage

### design/elv_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one enqueue or tick word.
// ----------------------------------------------------------------------------
interface elv_req_if;
   import elv_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   req_type;
   logic [FLOOR_W-1:0]     src_floor;
   logic [FLOOR_W-1:0]     dst_floor;
   logic [TAG_WIDTH-1:0]   tag;

   modport source (output valid, req_type, src_floor, dst_floor, tag, input ready);
   modport sink   (input valid, req_type, src_floor, dst_floor, tag, output ready);
endinterface

### design/elv_rsp_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one event word of the scheduler.
// ----------------------------------------------------------------------------
interface elv_rsp_if;
   import elv_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [2:0]             event_res;
   logic [TAG_WIDTH-1:0]   tag_res;
   logic [FLOOR_W-1:0]     floor;
   logic [LOAD_W-1:0]      load;
   logic [1:0]             direction;
   logic                   last;

   modport source (output valid, event_res, tag_res, floor, load, direction, last,
                   input ready);
   modport sink   (input valid, event_res, tag_res, floor, load, direction, last,
                   output ready);
endinterface

### design/elevator_look_scheduler.sv
// ----------------------------------------------------------------------------
// Elevator LOOK scheduler
// Single-car scheduler: request slot list, per-tick drop-off, pick-up and move.
// ----------------------------------------------------------------------------
// Usage. Words arrive on req_if. An enqueue word appends (from, to, tag) to
// the slot list and yields one accepted or rejected word on rsp_if in the
// cycle after it is taken; enqueue words can follow one per cycle while the
// receiver keeps up. A tick word runs the scheduling step: a compaction pass
// over the used slots, a decision state, a drop-off pass, a pick-up pass, a
// look-ahead pass and a finishing state. Each pass walks the used slots in
// order, and the tick ends at the decision state when nothing is left to
// serve. All passes go through one slot read port. Every drop-off and pick-up
// emits a word, and the step-end word, with last set, closes the tick.
// req_if.ready is high only while no tick is running and the single output
// register can take a word. If the receiver stalls, the sequencer holds at the
// slot that wants to emit until the register is free. Reset (synchronous,
// active high) empties the list, puts the car idle at floor 0 and loads
// floor_count 8 and car_capacity 4; configuration is written through
// csr_we/csr_index/csr_wdata; the user must write it only while the block is
// idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module elevator_look_scheduler (
   input  logic                       clock,
   input  logic                       reset,
   elv_req_if.sink                    req_if,
   elv_rsp_if.source                  rsp_if,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [elv_pkg::FCNT_W-1:0] csr_wdata
);
   import elv_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_COMPACT = 7'b0000010,
      S_DECIDE  = 7'b0000100,
      S_DROP    = 7'b0001000,
      S_PICK    = 7'b0010000,
      S_SCAN    = 7'b0100000,
      S_FINISH  = 7'b1000000
   } state_type;

   // Slot storage, no reset: only slots below the fill count are read.
   slot_type slot_ff [QUEUE_DEPTH];

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     used_ff, used_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     wr_ff, wr_in;
   logic [FLOOR_W-1:0]   floor_ff, floor_in;
   dir_type              dir_ff, dir_in;
   logic [LOAD_W-1:0]    rider_ff, rider_in;
   logic [FCNT_W-1:0]    fcount_ff, fcount_in;
   logic [LOAD_W-1:0]    cap_ff, cap_in;
   logic                 found_ff, found_in;
   dir_type              pd_ff, pd_in;
   logic                 cont_ff, cont_in;
   logic                 pend_ff, pend_in;

   logic                 ov_ff, ov_in;
   event_type            oev_ff, oev_in;
   logic [TAG_WIDTH-1:0] otag_ff, otag_in;
   logic [FLOOR_W-1:0]   ofloor_ff, ofloor_in;
   logic [LOAD_W-1:0]    oload_ff, oload_in;
   dir_type              odir_ff, odir_in;
   logic                 olast_ff, olast_in;

   logic                 slot_we;
   logic [IDX_W-1:0]     slot_waddr;
   slot_type             slot_wdata;

   logic                 out_free;
   logic                 req_take;
   slot_type             cur;
   logic                 at_end;
   logic [FCNT_W-1:0]    eff_floors;
   logic [FLOOR_W-1:0]   top_floor;
   dir_type              slot_dir;
   logic [FLOOR_W-1:0]   look_floor;
   dir_type              fin_dir;
   logic [FLOOR_W-1:0]   fin_floor;

   assign out_free = !ov_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == S_IDLE) && out_free;
   assign req_take = req_if.valid && req_if.ready;

   assign cur    = slot_ff[idx_ff[IDX_W-1:0]];
   assign at_end = (idx_ff == used_ff);

   // Floor count saturates to the range 2..64 where it is used.
   always_comb begin
      if (fcount_ff < FCNT_W'(2)) begin
         eff_floors = FCNT_W'(2);
      end else if (fcount_ff > FCNT_W'(64)) begin
         eff_floors = FCNT_W'(64);
      end else begin
         eff_floors = fcount_ff;
      end
   end
   assign top_floor = FLOOR_W'(eff_floors - FCNT_W'(1));

   // Direction that a waiting slot would give an idle car.
   always_comb begin
      if (cur.src_floor > floor_ff) begin
         slot_dir = DIR_UP;
      end else if (cur.src_floor < floor_ff) begin
         slot_dir = DIR_DN;
      end else if (cur.dst_floor > floor_ff) begin
         slot_dir = DIR_UP;
      end else if (cur.dst_floor < floor_ff) begin
         slot_dir = DIR_DN;
      end else begin
         slot_dir = DIR_NONE;
      end
   end

   assign look_floor = (cur.status == SLOT_WAIT) ? cur.src_floor : cur.dst_floor;

   // End of tick: reconsider, reverse at the ends, then move one floor.
   always_comb begin
      fin_dir   = dir_ff;
      fin_floor = floor_ff;
      if (!cont_ff && rider_ff == '0) begin
         fin_dir = pend_ff ? pd_ff : DIR_NONE;
      end
      if (floor_ff >= top_floor && fin_dir == DIR_UP) begin
         fin_dir = DIR_DN;
      end else if (floor_ff == '0 && fin_dir == DIR_DN) begin
         fin_dir = DIR_UP;
      end
      if (fin_dir == DIR_UP && floor_ff < top_floor) begin
         fin_floor = floor_ff + FLOOR_W'(1);
      end else if (fin_dir == DIR_DN && floor_ff > '0) begin
         fin_floor = floor_ff - FLOOR_W'(1);
      end
   end

   always_comb begin
      state_in  = state_ff;
      used_in   = used_ff;
      idx_in    = idx_ff;
      wr_in     = wr_ff;
      floor_in  = floor_ff;
      dir_in    = dir_ff;
      rider_in  = rider_ff;
      fcount_in = fcount_ff;
      cap_in    = cap_ff;
      found_in  = found_ff;
      pd_in     = pd_ff;
      cont_in   = cont_ff;
      pend_in   = pend_ff;
      ov_in     = ov_ff && !rsp_if.ready;
      oev_in    = oev_ff;
      otag_in   = otag_ff;
      ofloor_in = ofloor_ff;
      oload_in  = oload_ff;
      odir_in   = odir_ff;
      olast_in  = olast_ff;
      slot_we    = 1'b0;
      slot_waddr = idx_ff[IDX_W-1:0];
      slot_wdata = cur;

      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FLOOR_COUNT:  fcount_in = csr_wdata;
            CSR_CAR_CAPACITY: cap_in    = csr_wdata[LOAD_W-1:0];
            default:          fcount_in = fcount_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_if.req_type == REQ_ENQUEUE) begin
                  ov_in     = 1'b1;
                  otag_in   = req_if.tag;
                  ofloor_in = floor_ff;
                  oload_in  = rider_ff;
                  odir_in   = dir_ff;
                  olast_in  = 1'b1;
                  if (used_ff >= CNT_W'(QUEUE_DEPTH)
                      || {1'b0, req_if.src_floor} >= eff_floors
                      || {1'b0, req_if.dst_floor} >= eff_floors) begin
                     oev_in = EV_REJECTED;
                  end else begin
                     oev_in               = EV_ACCEPTED;
                     slot_we              = 1'b1;
                     slot_waddr           = used_ff[IDX_W-1:0];
                     slot_wdata.src_floor = req_if.src_floor;
                     slot_wdata.dst_floor = req_if.dst_floor;
                     slot_wdata.tag       = req_if.tag;
                     slot_wdata.status    = SLOT_WAIT;
                     used_in              = used_ff + CNT_W'(1);
                  end
               end else begin
                  state_in = S_COMPACT;
                  idx_in   = '0;
                  wr_in    = '0;
                  found_in = 1'b0;
                  pd_in    = DIR_NONE;
               end
            end
         end

         // Squeeze out delivered slots, and find the oldest waiter's direction.
         S_COMPACT: begin
            if (at_end) begin
               used_in  = wr_ff;
               state_in = S_DECIDE;
            end else begin
               if (cur.status != SLOT_DONE) begin
                  slot_we    = 1'b1;
                  slot_waddr = wr_ff[IDX_W-1:0];
                  wr_in      = wr_ff + CNT_W'(1);
                  if (!found_ff && cur.status == SLOT_WAIT && slot_dir != DIR_NONE) begin
                     found_in = 1'b1;
                     pd_in    = slot_dir;
                  end
               end
               idx_in = idx_ff + CNT_W'(1);
            end
         end

         S_DECIDE: begin
            if (used_ff == '0 || (dir_ff == DIR_NONE && pd_ff == DIR_NONE)) begin
               if (out_free) begin
                  dir_in    = DIR_NONE;
                  ov_in     = 1'b1;
                  oev_in    = EV_STEP_END;
                  otag_in   = '0;
                  ofloor_in = floor_ff;
                  oload_in  = rider_ff;
                  odir_in   = DIR_NONE;
                  olast_in  = 1'b1;
                  state_in  = S_IDLE;
               end
            end else begin
               if (dir_ff == DIR_NONE) begin
                  dir_in = pd_ff;
               end
               idx_in   = '0;
               state_in = S_DROP;
            end
         end

         S_DROP: begin
            if (at_end) begin
               idx_in   = '0;
               state_in = S_PICK;
            end else if (cur.status == SLOT_RIDE && cur.dst_floor == floor_ff) begin
               if (out_free) begin
                  slot_we           = 1'b1;
                  slot_wdata.status = SLOT_DONE;
                  rider_in  = (rider_ff != '0) ? rider_ff - LOAD_W'(1) : rider_ff;
                  ov_in     = 1'b1;
                  oev_in    = EV_DROP_OFF;
                  otag_in   = cur.tag;
                  ofloor_in = floor_ff;
                  oload_in  = rider_in;
                  odir_in   = dir_ff;
                  olast_in  = 1'b0;
                  idx_in    = idx_ff + CNT_W'(1);
               end
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end

         S_PICK: begin
            if (at_end) begin
               idx_in   = '0;
               found_in = 1'b0;
               pd_in    = DIR_NONE;
               cont_in  = 1'b0;
               pend_in  = 1'b0;
               state_in = S_SCAN;
            end else if (cur.status == SLOT_WAIT && cur.src_floor == floor_ff
                         && rider_ff < cap_ff) begin
               if (out_free) begin
                  slot_we           = 1'b1;
                  slot_wdata.status = SLOT_RIDE;
                  rider_in  = rider_ff + LOAD_W'(1);
                  ov_in     = 1'b1;
                  oev_in    = EV_PICK_UP;
                  otag_in   = cur.tag;
                  ofloor_in = floor_ff;
                  oload_in  = rider_in;
                  odir_in   = dir_ff;
                  olast_in  = 1'b0;
                  idx_in    = idx_ff + CNT_W'(1);
               end
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end

         // Look ahead in the travel direction and gather a fresh choice.
         S_SCAN: begin
            if (at_end) begin
               state_in = S_FINISH;
            end else begin
               if (cur.status != SLOT_DONE) begin
                  pend_in = 1'b1;
                  if ((dir_ff == DIR_UP && look_floor > floor_ff)
                      || (dir_ff == DIR_DN && look_floor < floor_ff)) begin
                     cont_in = 1'b1;
                  end
                  if (!found_ff && cur.status == SLOT_WAIT && slot_dir != DIR_NONE) begin
                     found_in = 1'b1;
                     pd_in    = slot_dir;
                  end
               end
               idx_in = idx_ff + CNT_W'(1);
            end
         end

         S_FINISH: begin
            if (out_free) begin
               dir_in    = fin_dir;
               floor_in  = fin_floor;
               ov_in     = 1'b1;
               oev_in    = EV_STEP_END;
               otag_in   = '0;
               ofloor_in = fin_floor;
               oload_in  = rider_ff;
               odir_in   = fin_dir;
               olast_in  = 1'b1;
               state_in  = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_ff[slot_waddr] <= slot_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         used_ff   <= '0;
         floor_ff  <= '0;
         dir_ff    <= DIR_NONE;
         rider_ff  <= '0;
         fcount_ff <= FCNT_W'(8);
         cap_ff    <= LOAD_W'(4);
         ov_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         used_ff   <= used_in;
         floor_ff  <= floor_in;
         dir_ff    <= dir_in;
         rider_ff  <= rider_in;
         fcount_ff <= fcount_in;
         cap_ff    <= cap_in;
         ov_ff     <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      wr_ff     <= wr_in;
      found_ff  <= found_in;
      pd_ff     <= pd_in;
      cont_ff   <= cont_in;
      pend_ff   <= pend_in;
      oev_ff    <= oev_in;
      otag_ff   <= otag_in;
      ofloor_ff <= ofloor_in;
      oload_ff  <= oload_in;
      odir_ff   <= odir_in;
      olast_ff  <= olast_in;
   end

   assign rsp_if.valid     = ov_ff;
   assign rsp_if.event_res = oev_ff;
   assign rsp_if.tag_res   = otag_ff;
   assign rsp_if.floor     = ofloor_ff;
   assign rsp_if.load      = oload_ff;
   assign rsp_if.direction = odir_ff;
   assign rsp_if.last      = olast_ff;

endmodule

### test/tb_elevator_look_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LOOK elevator scheduler testbench
// Drives enqueue and tick words in random bursts, stalls the result channel on
// a pattern of its own, and checks every event word against a cycle-free
// prediction of the scheduler, over several floor and capacity settings.
// ----------------------------------------------------------------------------
module tb_elevator_look_scheduler;
   import elv_pkg::*;

   typedef struct {
      req_kind_type         kind;
      logic [FLOOR_W-1:0]   src_floor;
      logic [FLOOR_W-1:0]   dst_floor;
      logic [TAG_WIDTH-1:0] tag;
   } req_word_type;

   typedef struct {
      event_type            ev;
      logic [TAG_WIDTH-1:0] tag;
      logic [FLOOR_W-1:0]   floor;
      logic [LOAD_W-1:0]    load;
      dir_type              dir;
      logic                 last;
   } event_word_type;

   localparam int CYCLE_LIMIT = 2000000;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_index;
   logic [FCNT_W-1:0] csr_wdata;

   elv_req_if req_if ();
   elv_rsp_if rsp_if ();

   elevator_look_scheduler uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Words waiting to be sent, and event words the scheduler still owes us.
   req_word_type   pending_words[$];
   event_word_type expected_events[$];
   int mismatches = 0;
   int cycles = 0;

   // Our own picture of the scheduler: slot list, car and configuration.
   slot_type             car_slots[QUEUE_DEPTH];
   int                   used_slots;
   int                   car_flr;
   dir_type              car_dir;
   int                   riders;
   int                   floors_reg;
   int                   capacity_reg;

   function automatic int usable_floors();
      if (floors_reg < 2) return 2;
      if (floors_reg > 64) return 64;
      return floors_reg;
   endfunction

   function automatic bit work_pending();
      for (int i = 0; i < used_slots; i++)
         if (car_slots[i].status != SLOT_DONE) return 1'b1;
      return 1'b0;
   endfunction

   // Direction towards the oldest waiter that is not already fully at the car.
   function automatic dir_type oldest_waiter_dir();
      for (int i = 0; i < used_slots; i++) begin
         if (car_slots[i].status != SLOT_WAIT) continue;
         if (car_slots[i].src_floor > car_flr) return DIR_UP;
         if (car_slots[i].src_floor < car_flr) return DIR_DN;
         if (car_slots[i].dst_floor > car_flr) return DIR_UP;
         if (car_slots[i].dst_floor < car_flr) return DIR_DN;
      end
      return DIR_NONE;
   endfunction

   task automatic note_event(event_type ev, logic [TAG_WIDTH-1:0] tag, logic last);
      event_word_type w;
      w.ev = ev;
      w.tag = tag;
      w.floor = car_flr[FLOOR_W-1:0];
      w.load = riders[LOAD_W-1:0];
      w.dir = car_dir;
      w.last = last;
      expected_events.push_back(w);
   endtask

   // Works out every event word that one accepted request word causes.
   task automatic schedule_word(req_word_type r);
      int wr;
      int f;
      int top;
      bit ahead;
      if (r.kind == REQ_ENQUEUE) begin
         if (used_slots >= QUEUE_DEPTH || r.src_floor >= usable_floors() ||
             r.dst_floor >= usable_floors()) begin
            note_event(EV_REJECTED, r.tag, 1'b1);
         end else begin
            car_slots[used_slots].src_floor = r.src_floor;
            car_slots[used_slots].dst_floor = r.dst_floor;
            car_slots[used_slots].tag = r.tag;
            car_slots[used_slots].status = SLOT_WAIT;
            used_slots++;
            note_event(EV_ACCEPTED, r.tag, 1'b1);
         end
         return;
      end
      // Delivered entries leave the list first, the rest keep their order.
      wr = 0;
      for (int i = 0; i < used_slots; i++)
         if (car_slots[i].status != SLOT_DONE) begin
            car_slots[wr] = car_slots[i];
            wr++;
         end
      used_slots = wr;
      if (!work_pending()) begin
         car_dir = DIR_NONE;
         note_event(EV_STEP_END, '0, 1'b1);
         return;
      end
      if (car_dir == DIR_NONE) begin
         car_dir = oldest_waiter_dir();
         // Only waiters already at their goal: the car stays put.
         if (car_dir == DIR_NONE) begin
            note_event(EV_STEP_END, '0, 1'b1);
            return;
         end
      end
      for (int i = 0; i < used_slots; i++)
         if (car_slots[i].status == SLOT_RIDE && car_slots[i].dst_floor == car_flr) begin
            car_slots[i].status = SLOT_DONE;
            if (riders > 0) riders--;
            note_event(EV_DROP_OFF, car_slots[i].tag, 1'b0);
         end
      for (int i = 0; i < used_slots; i++)
         if (car_slots[i].status == SLOT_WAIT && car_slots[i].src_floor == car_flr &&
             riders < capacity_reg) begin
            car_slots[i].status = SLOT_RIDE;
            riders++;
            note_event(EV_PICK_UP, car_slots[i].tag, 1'b0);
         end
      ahead = 1'b0;
      for (int i = 0; i < used_slots && !ahead; i++) begin
         if (car_slots[i].status == SLOT_WAIT) f = car_slots[i].src_floor;
         else if (car_slots[i].status == SLOT_RIDE) f = car_slots[i].dst_floor;
         else continue;
         if (car_dir == DIR_UP && f > car_flr) ahead = 1'b1;
         if (car_dir == DIR_DN && f < car_flr) ahead = 1'b1;
      end
      if (!ahead && riders == 0)
         car_dir = work_pending() ? oldest_waiter_dir() : DIR_NONE;
      // A car at or above the top floor (floor count lowered) turns down.
      top = usable_floors() - 1;
      if (car_flr >= top && car_dir == DIR_UP) car_dir = DIR_DN;
      else if (car_flr == 0 && car_dir == DIR_DN) car_dir = DIR_UP;
      if (car_dir == DIR_UP && car_flr < top) car_flr++;
      else if (car_dir == DIR_DN && car_flr > 0) car_flr--;
      note_event(EV_STEP_END, '0, 1'b1);
   endtask

   // Sender: bursts of words with random gaps between them. The word on the
   // bus is handed to the predictor at the edge where it is taken.
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      req_word_type nxt;
      req_word_type sent;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            sent.kind = req_kind_type'(req_if.req_type);
            sent.src_floor = req_if.src_floor;
            sent.dst_floor = req_if.dst_floor;
            sent.tag = req_if.tag;
            schedule_word(sent);
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               nxt = pending_words.pop_front();
               req_if.valid <= 1'b1;
               req_if.req_type <= nxt.kind;
               req_if.src_floor <= nxt.src_floor;
               req_if.dst_floor <= nxt.dst_floor;
               req_if.tag <= nxt.tag;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(0, 6);
                  gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: runs of ready and stalls of random length, now and then long.
   int rsp_run = 0;
   always @(posedge clock) begin
      event_word_type want;
      if (rsp_if.valid && rsp_if.ready && !reset) begin
         if (expected_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected event word %0d tag %0d", rsp_if.event_res, rsp_if.tag_res);
         end else begin
            want = expected_events.pop_front();
            if (rsp_if.event_res !== want.ev || rsp_if.tag_res !== want.tag ||
                rsp_if.floor !== want.floor || rsp_if.load !== want.load ||
                rsp_if.direction !== want.dir || rsp_if.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"Mismatch: expected ev %0d tag %0d fl %0d ld %0d dir %0d ",
                            "last %0d, got ev %0d tag %0d fl %0d ld %0d dir %0d last %0d"},
                           want.ev, want.tag, want.floor, want.load, want.dir, want.last,
                           rsp_if.event_res, rsp_if.tag_res, rsp_if.floor, rsp_if.load,
                           rsp_if.direction, rsp_if.last);
            end
         end
      end
      if (rsp_run > 0) begin
         rsp_run--;
      end else if (rsp_if.ready) begin
         rsp_if.ready <= 1'b0;
         rsp_run = $urandom_range(0, 7) == 0 ? $urandom_range(10, 30) : $urandom_range(0, 4);
      end else begin
         rsp_if.ready <= 1'b1;
         rsp_run = $urandom_range(0, 20);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic queue_word(req_kind_type k, int fr, int to, int tg);
      req_word_type r;
      r.kind = k;
      r.src_floor = fr[FLOOR_W-1:0];
      r.dst_floor = to[FLOOR_W-1:0];
      r.tag = tg[TAG_WIDTH-1:0];
      pending_words.push_back(r);
   endtask

   // Waits until every word is sent and every event word has come back.
   task automatic drain();
      @(negedge clock);
      while (pending_words.size() > 0 || req_if.valid || expected_events.size() > 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, int value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[FCNT_W-1:0];
      if (idx == CSR_FLOOR_COUNT) floors_reg = value & 8'h7f;
      else capacity_reg = value & 8'h1f;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly in-range requests with ticks between them, plus some noise.
   task automatic random_phase(int count);
      int enq_pct;
      int nf;
      enq_pct = $urandom_range(30, 75);
      nf = usable_floors();
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < enq_pct) begin
            if ($urandom_range(0, 9) == 0)
               queue_word(REQ_ENQUEUE, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 255));
            else
               queue_word(REQ_ENQUEUE, $urandom_range(0, nf - 1), $urandom_range(0, nf - 1),
                          $urandom_range(0, 255));
         end else begin
            queue_word(REQ_TICK, $urandom_range(0, 63), $urandom_range(0, 63),
                       $urandom_range(0, 255));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_FLOOR_COUNT;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.req_type = REQ_ENQUEUE;
      req_if.src_floor = '0;
      req_if.dst_floor = '0;
      req_if.tag = '0;
      rsp_if.ready = 1'b0;
      used_slots = 0;
      car_flr = 0;
      car_dir = DIR_NONE;
      riders = 0;
      floors_reg = 8;
      capacity_reg = 4;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: a waiter already at the car floor leaves the car idle, then
      // tag and floor extremes, out-of-range floors and a run of ticks.
      queue_word(REQ_ENQUEUE, 0, 0, 0);
      queue_word(REQ_TICK, 0, 0, 0);
      queue_word(REQ_ENQUEUE, 7, 0, 255);
      queue_word(REQ_ENQUEUE, 8, 1, 1);
      queue_word(REQ_ENQUEUE, 1, 63, 2);
      queue_word(REQ_ENQUEUE, 63, 63, 170);
      queue_word(REQ_ENQUEUE, 3, 5, 85);
      for (int i = 0; i < 8; i++) queue_word(REQ_TICK, 63, 63, 255);
      drain();

      // No capacity on a two-floor building: the list fills and overflows.
      write_csr(CSR_CAR_CAPACITY, 0);
      write_csr(CSR_FLOOR_COUNT, 2);
      for (int i = 0; i < 16; i++) queue_word(REQ_ENQUEUE, 1, 0, 16 + i);
      queue_word(REQ_TICK, 0, 0, 0);
      queue_word(REQ_TICK, 0, 0, 0);
      drain();

      // Tallest building and a full car; the car climbs high.
      write_csr(CSR_FLOOR_COUNT, 64);
      write_csr(CSR_CAR_CAPACITY, 16);
      queue_word(REQ_ENQUEUE, 63, 62, 201);
      for (int i = 0; i < 12; i++) queue_word(REQ_TICK, 0, 0, 0);
      random_phase(40);
      drain();

      // Floor count lowered under the car, then out-of-range register values.
      write_csr(CSR_FLOOR_COUNT, 5);
      write_csr(CSR_CAR_CAPACITY, 2);
      random_phase(35);
      drain();
      write_csr(CSR_FLOOR_COUNT, 0);
      write_csr(CSR_CAR_CAPACITY, 1);
      random_phase(35);
      drain();
      write_csr(CSR_FLOOR_COUNT, 127);
      write_csr(CSR_CAR_CAPACITY, 31);
      random_phase(40);
      drain();
      write_csr(CSR_FLOOR_COUNT, 13);
      write_csr(CSR_CAR_CAPACITY, 3);
      random_phase(40);
      drain();
      write_csr(CSR_FLOOR_COUNT, 1);
      write_csr(CSR_CAR_CAPACITY, 4);
      random_phase(30);
      drain();
      write_csr(CSR_FLOOR_COUNT, 64);
      write_csr(CSR_CAR_CAPACITY, 8);
      random_phase(50);
      drain();
      repeat (100) @(posedge clock);

      if (mismatches == 0 && expected_events.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
design/elv_pkg.sv
design/elv_req_if.sv
design/elv_rsp_if.sv
design/elevator_look_scheduler.sv
test/tb_elevator_look_scheduler.sv
